// ===== src/lhm_pkg.sv =====
// Types, codes and reset constants shared by the latency health monitor modules.
package lhm_pkg;

    localparam int SampleWidth = 32;
    localparam int WeightWidth = 8;
    localparam int CfgIndexWidth = 3;
    localparam int AccWidth = SampleWidth + WeightWidth + 1;
    localparam int DivCountWidth = $clog2(SampleWidth);

    localparam logic [CfgIndexWidth-1:0] REG_PEAK_HIGH = 3'd0;
    localparam logic [CfgIndexWidth-1:0] REG_PEAK_LOW  = 3'd1;
    localparam logic [CfgIndexWidth-1:0] REG_MEAN_HIGH = 3'd2;
    localparam logic [CfgIndexWidth-1:0] REG_MEAN_LOW  = 3'd3;
    localparam logic [CfgIndexWidth-1:0] REG_FAST_WGT  = 3'd4;
    localparam logic [CfgIndexWidth-1:0] REG_SLOW_WGT  = 3'd5;

    localparam logic [SampleWidth-1:0] PEAK_HIGH_RST = 32'd40000000;
    localparam logic [SampleWidth-1:0] PEAK_LOW_RST  = 32'd3000000;
    localparam logic [SampleWidth-1:0] MEAN_HIGH_RST = 32'd2500000;
    localparam logic [SampleWidth-1:0] MEAN_LOW_RST  = 32'd2000000;
    localparam logic [WeightWidth-1:0] FAST_WGT_RST  = 8'd8;
    localparam logic [WeightWidth-1:0] SLOW_WGT_RST  = 8'd30;

    typedef enum logic [1:0] {
        ACT_NONE    = 2'd0,
        ACT_SUSPEND = 2'd1,
        ACT_RESUME  = 2'd2
    } action_t;

    typedef enum logic [2:0] {
        VERD_TICK       = 3'd0,
        VERD_MEAN_HIGH  = 3'd1,
        VERD_PEAK       = 3'd2,
        VERD_GOOD       = 3'd3,
        VERD_MEAN_GOOD  = 3'd4,
        VERD_STILL_HIGH = 3'd5
    } verdict_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL_FAST,
        ST_DIV_FAST,
        ST_MUL_SLOW,
        ST_DIV_SLOW,
        ST_DECIDE
    } state_t;

    typedef struct packed {
        logic [SampleWidth-1:0] peak_high;
        logic [SampleWidth-1:0] peak_low;
        logic [SampleWidth-1:0] mean_high;
        logic [SampleWidth-1:0] mean_low;
        logic [WeightWidth-1:0] fast_weight;
        logic [WeightWidth-1:0] slow_weight;
    } cfg_t;

    typedef struct packed {
        logic load_in;
        logic mul;
        logic div_step;
        logic sel_slow;
        logic commit;
    } cmd_t;

    typedef struct packed {
        logic is_pong;
        logic div_last;
        logic out_free;
    } status_t;

endpackage

// ===== src/latency_health_monitor_top.sv =====
// Top level of the latency health monitor: stream ports, configuration port, submodules.
//
// Each item is a tick or a pong. A tick passes ST_MUL_FAST and ST_DECIDE after its acceptance. A pong
// passes a multiply-add and 32 divider steps for the fast average, the same again for the slow average
// on the one shared bit-serial divider, and then the threshold cascade in ST_DECIDE, where the result
// is taken into the result register. One item is worked on at a time; the next is accepted the cycle
// after the previous one has reached the result register, even while that result waits for m_tready.
// Configuration writes are taken every cycle (cfg_ready is tied high) and belong between items, while
// nothing is in flight.
module latency_health_monitor_top #(
    parameter int SAMPLE_BITS = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // round_trip_ns[31:0], link_suspended[32], zero pad
    input  logic        s_tuser,   // req_type
    output logic        m_tvalid,
    input  logic        m_tready,
    // send_ping[0], action[2:1], verdict[5:3], fast_avg_ns[37:6], slow_avg_ns[69:38], zero pad
    output logic [71:0] m_tdata,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data
);
    import lhm_pkg::*;

    cfg_t     cfg;
    cmd_t     cmd;
    status_t  status;
    logic     o_send;
    action_t  o_action;
    verdict_t o_verdict;
    logic [SampleWidth-1:0] o_fast, o_slow;

    assign cfg_ready = 1'b1;

    lhm_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    lhm_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    lhm_datapath #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg           (cfg),
        .cmd           (cmd),
        .status        (status),
        .in_pong       (s_tuser),
        .in_sample     (s_tdata[31:0]),
        .in_link_susp  (s_tdata[32]),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .out_send_ping (o_send),
        .out_action    (o_action),
        .out_verdict   (o_verdict),
        .out_fast      (o_fast),
        .out_slow      (o_slow)
    );

    assign m_tdata = {2'b00, o_slow, o_fast, o_verdict, o_action, o_send};

endmodule

// ===== src/lhm_cfg_regs.sv =====
// Configuration register file of the latency health monitor.
module lhm_cfg_regs (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_valid,
    input  logic [lhm_pkg::CfgIndexWidth-1:0] cfg_index,
    input  logic [lhm_pkg::SampleWidth-1:0]   cfg_data,
    output lhm_pkg::cfg_t                     cfg
);
    import lhm_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            case (cfg_index)
                REG_PEAK_HIGH: cfg_next.peak_high = cfg_data;
                REG_PEAK_LOW:  cfg_next.peak_low = cfg_data;
                REG_MEAN_HIGH: cfg_next.mean_high = cfg_data;
                REG_MEAN_LOW:  cfg_next.mean_low = cfg_data;
                REG_FAST_WGT:  cfg_next.fast_weight = cfg_data[WeightWidth-1:0];
                REG_SLOW_WGT:  cfg_next.slow_weight = cfg_data[WeightWidth-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.peak_high   <= PEAK_HIGH_RST;
            cfg_reg.peak_low    <= PEAK_LOW_RST;
            cfg_reg.mean_high   <= MEAN_HIGH_RST;
            cfg_reg.mean_low    <= MEAN_LOW_RST;
            cfg_reg.fast_weight <= FAST_WGT_RST;
            cfg_reg.slow_weight <= SLOW_WGT_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== src/lhm_ctrl.sv =====
// Sequencing state machine of the latency health monitor.
module lhm_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  lhm_pkg::status_t  status,
    output lhm_pkg::cmd_t     cmd
);
    import lhm_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd = '0;
        s_tready = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load_in = 1'b1;
                    state_next = ST_MUL_FAST;
                end
            end
            ST_MUL_FAST: begin
                cmd.mul = 1'b1;
                state_next = status.is_pong ? ST_DIV_FAST : ST_DECIDE;
            end
            ST_DIV_FAST: begin
                cmd.div_step = 1'b1;
                if (status.div_last) begin
                    state_next = ST_MUL_SLOW;
                end
            end
            ST_MUL_SLOW: begin
                cmd.mul = 1'b1;
                cmd.sel_slow = 1'b1;
                state_next = ST_DIV_SLOW;
            end
            ST_DIV_SLOW: begin
                cmd.div_step = 1'b1;
                cmd.sel_slow = 1'b1;
                if (status.div_last) begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                if (status.out_free) begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

endmodule

// ===== src/lhm_datapath.sv =====
// Averaging, shared serial divider, threshold cascade and result register.
module lhm_datapath #(
    parameter int SAMPLE_BITS = 32
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  lhm_pkg::cfg_t                   cfg,
    input  lhm_pkg::cmd_t                   cmd,
    output lhm_pkg::status_t                status,
    input  logic                            in_pong,
    input  logic [lhm_pkg::SampleWidth-1:0] in_sample,
    input  logic                            in_link_susp,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic                            out_send_ping,
    output lhm_pkg::action_t                out_action,
    output lhm_pkg::verdict_t               out_verdict,
    output logic [lhm_pkg::SampleWidth-1:0] out_fast,
    output logic [lhm_pkg::SampleWidth-1:0] out_slow
);
    import lhm_pkg::*;

    localparam int SW = (SAMPLE_BITS >= SampleWidth) ? SampleWidth : SAMPLE_BITS;

    logic [SW-1:0] sat_sample;

    generate
        if (SW < SampleWidth) begin : g_sat
            assign sat_sample = (|in_sample[SampleWidth-1:SW]) ? {SW{1'b1}} : in_sample[SW-1:0];
        end else begin : g_nosat
            assign sat_sample = in_sample;
        end
    endgenerate

    logic                     pong_reg;
    logic                     link_susp_reg;
    logic [SW-1:0]            sample_reg;
    logic [WeightWidth-1:0]   rem_reg, rem_next;
    logic [SampleWidth-1:0]   quo_reg, quo_next;
    logic [DivCountWidth-1:0] cnt_reg;
    logic [SampleWidth-1:0]   fast_new_reg;
    logic                     ping_pending_reg;
    logic                     mon_susp_reg;
    logic [SampleWidth-1:0]   fast_avg_reg;
    logic [SampleWidth-1:0]   slow_avg_reg;
    logic                     m_valid_reg;
    logic                     send_reg;
    action_t                  action_reg;
    verdict_t                 verdict_reg;
    logic [SampleWidth-1:0]   ofast_reg, oslow_reg;

    // zero weight behaves as one
    logic [WeightWidth-1:0] w_raw, w_eff, w_m1;
    logic [SampleWidth-1:0] prev;
    logic [AccWidth-1:0]    acc;
    logic [WeightWidth:0]   trial;
    logic                   ge;

    assign w_raw = cmd.sel_slow ? cfg.slow_weight : cfg.fast_weight;
    assign w_eff = (w_raw == '0) ? WeightWidth'(1) : w_raw;
    assign w_m1  = w_eff - WeightWidth'(1);
    assign prev  = cmd.sel_slow ? slow_avg_reg : fast_avg_reg;
    assign acc   = AccWidth'(prev) * AccWidth'(w_m1) + AccWidth'(SampleWidth'(sample_reg));

    assign trial    = {rem_reg, quo_reg[SampleWidth-1]};
    assign ge       = trial >= {1'b0, w_eff};
    assign rem_next = ge ? WeightWidth'(trial - {1'b0, w_eff}) : trial[WeightWidth-1:0];
    assign quo_next = {quo_reg[SampleWidth-2:0], ge};

    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            pong_reg      <= in_pong;
            link_susp_reg <= in_link_susp;
            sample_reg    <= sat_sample;
        end
        if (cmd.mul) begin
            // quotient fits the sample width, so the high part starts below the weight
            rem_reg <= acc[SampleWidth+WeightWidth-1:SampleWidth];
            quo_reg <= acc[SampleWidth-1:0];
            if (cmd.sel_slow) begin
                fast_new_reg <= quo_reg;
            end
        end else if (cmd.div_step) begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else if (cmd.mul) begin
            cnt_reg <= '0;
        end else if (cmd.div_step) begin
            cnt_reg <= cnt_reg + DivCountWidth'(1);
        end
    end

    // result of the current item
    logic     d_send, d_pending, d_mon;
    action_t  d_action;
    verdict_t d_verdict;
    logic [SampleWidth-1:0] d_fast, d_slow;
    logic     mine;

    always_comb begin
        d_send    = 1'b0;
        d_action  = ACT_NONE;
        d_verdict = VERD_TICK;
        d_pending = ping_pending_reg;
        d_mon     = mon_susp_reg;
        d_fast    = fast_avg_reg;
        d_slow    = slow_avg_reg;
        mine      = link_susp_reg & mon_susp_reg;
        if (!pong_reg) begin
            if (ping_pending_reg) begin
                d_action = ACT_SUSPEND;
                d_mon    = 1'b1;
            end else begin
                d_send    = 1'b1;
                d_pending = 1'b1;
            end
        end else begin
            d_pending = 1'b0;
            d_fast    = fast_new_reg;
            d_slow    = quo_reg;
            if (d_slow > cfg.mean_high) begin
                d_verdict = VERD_MEAN_HIGH;
                d_action  = ACT_SUSPEND;
                d_mon     = 1'b1;
            end else if (d_fast > cfg.peak_high) begin
                d_verdict = VERD_PEAK;
                d_action  = ACT_SUSPEND;
                d_mon     = 1'b1;
            end else if (d_fast < cfg.peak_low) begin
                d_verdict = VERD_GOOD;
                if (mine) begin
                    d_action = ACT_RESUME;
                    d_mon    = 1'b0;
                end
            end else if (d_slow < cfg.mean_low) begin
                d_verdict = VERD_MEAN_GOOD;
                if (mine) begin
                    d_action = ACT_RESUME;
                    d_mon    = 1'b0;
                end
            end else begin
                d_verdict = VERD_STILL_HIGH;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ping_pending_reg <= 1'b0;
            mon_susp_reg     <= 1'b0;
            fast_avg_reg     <= '0;
            slow_avg_reg     <= '0;
            m_valid_reg      <= 1'b0;
        end else begin
            if (cmd.commit) begin
                ping_pending_reg <= d_pending;
                mon_susp_reg     <= d_mon;
                fast_avg_reg     <= d_fast;
                slow_avg_reg     <= d_slow;
                m_valid_reg      <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.commit) begin
            send_reg    <= d_send;
            action_reg  <= d_action;
            verdict_reg <= d_verdict;
            ofast_reg   <= d_fast;
            oslow_reg   <= d_slow;
        end
    end

    assign status.is_pong  = pong_reg;
    assign status.div_last = (cnt_reg == DivCountWidth'(SampleWidth - 1));
    assign status.out_free = ~m_valid_reg | m_tready;

    assign m_tvalid      = m_valid_reg;
    assign out_send_ping = send_reg;
    assign out_action    = action_reg;
    assign out_verdict   = verdict_reg;
    assign out_fast      = ofast_reg;
    assign out_slow      = oslow_reg;

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for the latency health monitor: directed and random tick/pong items.
`timescale 1ns / 100ps

module tb_top;
    import lhm_pkg::*;

    localparam int CLK_PERIOD = 12;
    localparam int CYCLE_LIMIT = 2_000_000;
    localparam int HOLD_CYCLES = 400;
    localparam int DRAIN_CYCLES = 100;
    localparam int SETTLE_CYCLES = 4;
    localparam logic REQ_TICK = 1'b0;
    localparam logic REQ_PONG = 1'b1;

    typedef struct {
        logic        send_ping;
        action_t     action;
        verdict_t    verdict;
        logic [31:0] fast_avg;
        logic [31:0] slow_avg;
    } health_rec_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [39:0] s_tdata;
    logic        s_tuser;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [71:0] m_tdata;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_index;
    logic [31:0] cfg_data;

    // predictor copy of the configuration and state
    logic [31:0] cfg_peak_high, cfg_peak_low, cfg_mean_high, cfg_mean_low;
    logic [7:0]  cfg_fast_wgt, cfg_slow_wgt;
    logic        ping_out, mon_susp;
    logic [31:0] fast_est, slow_est;

    health_rec_t  expected_q[$];
    int           mismatches = 0;
    int           idle_pct;
    int           stall_pct;
    logic         hold_req;
    logic         hold_ack = 1'b0;
    int           hold_left = 0;
    int unsigned  cycles = 0;

    latency_health_monitor_top i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #(CLK_PERIOD / 2) aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    function automatic logic [31:0] smooth_avg(logic [31:0] prev, logic [31:0] sample,
                                               logic [7:0] wgt);
        logic [63:0] w;
        logic [63:0] acc;
        w = (wgt == 8'd0) ? 64'd1 : {56'd0, wgt};
        acc = {32'd0, prev} * (w - 64'd1) + {32'd0, sample};
        return 32'(acc / w);
    endfunction

    function automatic health_rec_t next_health(logic req, logic [31:0] rtt, logic link_susp);
        health_rec_t r;
        logic        mine;
        r.send_ping = 1'b0;
        r.action = ACT_NONE;
        r.verdict = VERD_TICK;
        if (req == REQ_TICK) begin
            if (ping_out) begin
                r.action = ACT_SUSPEND;
                mon_susp = 1'b1;
            end else begin
                r.send_ping = 1'b1;
                ping_out = 1'b1;
            end
        end else begin
            mine = link_susp && mon_susp;
            ping_out = 1'b0;
            fast_est = smooth_avg(fast_est, rtt, cfg_fast_wgt);
            slow_est = smooth_avg(slow_est, rtt, cfg_slow_wgt);
            if (slow_est > cfg_mean_high) begin
                r.verdict = VERD_MEAN_HIGH;
                r.action = ACT_SUSPEND;
            end else if (fast_est > cfg_peak_high) begin
                r.verdict = VERD_PEAK;
                r.action = ACT_SUSPEND;
            end else if (fast_est < cfg_peak_low) begin
                r.verdict = VERD_GOOD;
                if (mine) r.action = ACT_RESUME;
            end else if (slow_est < cfg_mean_low) begin
                r.verdict = VERD_MEAN_GOOD;
                if (mine) r.action = ACT_RESUME;
            end else begin
                r.verdict = VERD_STILL_HIGH;
            end
            if (r.action == ACT_SUSPEND) mon_susp = 1'b1;
            if (r.action == ACT_RESUME) mon_susp = 1'b0;
        end
        r.fast_avg = fast_est;
        r.slow_avg = slow_est;
        return r;
    endfunction

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge aclk) begin
        health_rec_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_q.size() == 0) begin
                $error("result item with none expected: %h", m_tdata);
                mismatches++;
            end else begin
                want = expected_q.pop_front();
                check_field("send_ping", 32'(want.send_ping), 32'(m_tdata[0]));
                check_field("action", 32'(want.action), 32'(m_tdata[2:1]));
                check_field("verdict", 32'(want.verdict), 32'(m_tdata[5:3]));
                check_field("fast_avg_ns", want.fast_avg, m_tdata[37:6]);
                check_field("slow_avg_ns", want.slow_avg, m_tdata[69:38]);
            end
        end
    end

    // result side: random stalls, plus a long hold-off on request
    always @(posedge aclk) begin
        if (hold_req != hold_ack) begin
            hold_ack <= hold_req;
            hold_left <= HOLD_CYCLES;
            m_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    task automatic send_item(logic req, logic [31:0] rtt, logic link_susp);
        int gap;
        s_tvalid <= 1'b1;
        s_tuser <= req;
        s_tdata <= {7'd0, link_susp, rtt};
        do @(posedge aclk); while (!s_tready);
        expected_q.push_back(next_health(req, rtt, link_susp));
        gap = 0;
        while ($urandom_range(99) < idle_pct) gap++;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (expected_q.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            REG_PEAK_HIGH: cfg_peak_high = val;
            REG_PEAK_LOW:  cfg_peak_low = val;
            REG_MEAN_HIGH: cfg_mean_high = val;
            REG_MEAN_LOW:  cfg_mean_low = val;
            REG_FAST_WGT:  cfg_fast_wgt = val[7:0];
            REG_SLOW_WGT:  cfg_slow_wgt = val[7:0];
            default: ;
        endcase
        @(posedge aclk);
    endtask

    task automatic set_config(logic [31:0] peak_high, logic [31:0] peak_low,
                              logic [31:0] mean_high, logic [31:0] mean_low,
                              logic [7:0] fast_wgt, logic [7:0] slow_wgt);
        wait_idle();
        write_reg(REG_PEAK_HIGH, peak_high);
        write_reg(REG_PEAK_LOW, peak_low);
        write_reg(REG_MEAN_HIGH, mean_high);
        write_reg(REG_MEAN_LOW, mean_low);
        write_reg(REG_FAST_WGT, {24'd0, fast_wgt});
        write_reg(REG_SLOW_WGT, {24'd0, slow_wgt});
    endtask

    function automatic logic [7:0] pick_weight();
        case ($urandom_range(7))
            0: return 8'd1;
            1: return 8'd255;
            2: return 8'd0;
            default: return 8'($urandom_range(1, 40));
        endcase
    endfunction

    function automatic logic [31:0] pick_sample(logic [31:0] unit);
        case ($urandom_range(11))
            0: return 32'd0;
            1: return 32'hFFFF_FFFF;
            2: return $urandom();
            default: return $urandom_range(0, unit * 8);
        endcase
    endfunction

    // mostly follow the monitor's own suspend state, as a real link would
    function automatic logic pick_link();
        if ($urandom_range(99) < 80) return mon_susp;
        return 1'($urandom_range(1));
    endfunction

    task automatic test_tick_pong_basics();
        send_item(REQ_PONG, 32'd0, 1'b0);           // pong with no ping out
        send_item(REQ_TICK, 32'd0, 1'b0);
        send_item(REQ_TICK, 32'd0, 1'b0);           // unanswered ping: suspend
        send_item(REQ_TICK, 32'd0, 1'b1);           // suspend repeated
        send_item(REQ_PONG, 32'd0, 1'b1);           // good: resume
        send_item(REQ_PONG, 32'hFFFF_FFFF, 1'b0);
        send_item(REQ_TICK, 32'hFFFF_FFFF, 1'b1);   // sample field ignored on tick
        send_item(REQ_PONG, 32'hFFFF_FFFF, 1'b1);
    endtask

    task automatic test_threshold_cascade();
        set_config(32'd1000, 32'd100, 32'd5000, 32'd200, 8'd1, 8'd1);
        send_item(REQ_PONG, 32'd6000, 1'b0);
        send_item(REQ_PONG, 32'd2000, 1'b0);
        send_item(REQ_PONG, 32'd50, 1'b1);
        send_item(REQ_PONG, 32'd500, 1'b0);
        send_item(REQ_PONG, 32'd2000, 1'b1);
        send_item(REQ_PONG, 32'd150, 1'b1);
    endtask

    task automatic test_weight_extremes();
        set_config(32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0, 8'd0, 8'd255);
        send_item(REQ_PONG, 32'hFFFF_FFFF, 1'b0);
        send_item(REQ_PONG, 32'd0, 1'b1);
        send_item(REQ_PONG, 32'hFFFF_FFFF, 1'b1);
        set_config(32'hFFFF_FFFF, 32'd0, 32'd0, 32'hFFFF_FFFF, 8'd255, 8'd0);
        send_item(REQ_PONG, 32'hAAAA_AAAA, 1'b1);
        send_item(REQ_PONG, 32'h5555_5555, 1'b0);
        send_item(REQ_PONG, 32'd0, 1'b1);
    endtask

    task automatic test_output_backpressure();
        set_config(PEAK_HIGH_RST, PEAK_LOW_RST, MEAN_HIGH_RST, MEAN_LOW_RST,
                   FAST_WGT_RST, SLOW_WGT_RST);
        idle_pct = 0;
        stall_pct = 0;
        hold_req = ~hold_req;
        repeat (5) begin
            send_item(REQ_TICK, $urandom(), pick_link());
            send_item(REQ_PONG, pick_sample(32'd1 << 20), pick_link());
        end
    endtask

    task automatic random_traffic(int count, logic [31:0] unit);
        int n;
        n = 0;
        while (n < count) begin
            if ($urandom_range(99) < 85) begin
                send_item(REQ_TICK, $urandom(), pick_link());
                if ($urandom_range(99) < 15) begin
                    send_item(REQ_TICK, $urandom(), pick_link());
                    n++;
                end
                send_item(REQ_PONG, pick_sample(unit), pick_link());
                n += 2;
            end else begin
                send_item(1'($urandom_range(1)), $urandom(), 1'($urandom_range(1)));
                n++;
            end
        end
    endtask

    task automatic test_random_traffic();
        int          pcts[4][2] = '{'{0, 0}, '{73, 0}, '{0, 73}, '{7, 7}};
        logic [31:0] unit;
        logic [31:0] peak_low, mean_low, mean_high, peak_high;
        for (int ph = 0; ph < 4; ph++) begin
            for (int k = 0; k < 3; k++) begin
                unit = 32'd1 << $urandom_range(4, 27);
                peak_low = unit * $urandom_range(1, 3);
                mean_low = unit * $urandom_range(1, 3);
                mean_high = mean_low + unit * $urandom_range(0, 3);
                peak_high = peak_low + unit * $urandom_range(1, 6);
                if ($urandom_range(5) == 0) mean_high = 32'hFFFF_FFFF;
                if ($urandom_range(5) == 0) peak_low = 32'd0;
                set_config(peak_high, peak_low, mean_high, mean_low,
                           pick_weight(), pick_weight());
                idle_pct = pcts[ph][0];
                stall_pct = pcts[ph][1];
                random_traffic(125, unit);
            end
        end
    endtask

    initial begin
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        idle_pct = 0;
        stall_pct = 0;
        hold_req = 1'b0;
        cfg_peak_high = PEAK_HIGH_RST;
        cfg_peak_low = PEAK_LOW_RST;
        cfg_mean_high = MEAN_HIGH_RST;
        cfg_mean_low = MEAN_LOW_RST;
        cfg_fast_wgt = FAST_WGT_RST;
        cfg_slow_wgt = SLOW_WGT_RST;
        ping_out = 1'b0;
        mon_susp = 1'b0;
        fast_est = '0;
        slow_est = '0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        test_tick_pong_basics();
        test_threshold_cascade();
        test_weight_extremes();
        test_output_backpressure();
        test_random_traffic();

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatches == 0 && expected_q.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
